>>> rtl/core/smae_pkg.sv
package smae_pkg;

   // table geometry
   localparam int NUM_SYMS = 257;
   localparam int IDX_W    = 9;
   localparam logic [IDX_W-1:0] END_SYM = 9'd256;
   localparam int CUM_W    = 25;
   localparam logic [CUM_W-1:0] CUM_MAX = 25'h1FF_FFFF;

   // request fields
   localparam int OP_W    = 2;
   localparam int FREQ_W  = 16;
   localparam int SYM_W   = 8;
   localparam int FREQ_BITS_DEF = 16;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   // coder interval
   localparam int CODE_W = 32;
   localparam logic [CODE_W-1:0] TOP       = 32'hFFFF_FFFF;
   localparam logic [CODE_W-1:0] HALF      = 32'h8000_0000;
   localparam logic [CODE_W-1:0] QTR       = 32'h4000_0000;
   localparam logic [CODE_W-1:0] THREE_QTR = 32'hC000_0000;

   // multiply / divide unit
   localparam int RANGE_W   = CODE_W + 1;
   localparam int PROD_W    = RANGE_W + CUM_W;
   localparam int DIV_STEPS = RANGE_W;
   localparam int STEP_W    = 6;

   typedef struct packed {
      logic start;
   } muldiv_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } muldiv_stat_type;

   function automatic logic [CUM_W-1:0] clamp_cum(input logic [CUM_W-1:0] value,
                                                  input logic [CUM_W-1:0] limit);
      clamp_cum = (value > limit) ? limit : value;
   endfunction

endpackage

>>> rtl/core/smae_cum_table.sv
module smae_cum_table (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [smae_pkg::IDX_W-1:0]     wr_addr,
   input  logic [smae_pkg::CUM_W-1:0]     wr_data,
   input  logic [smae_pkg::IDX_W-1:0]     rd_addr,
   output logic [smae_pkg::CUM_W-1:0]     rd_data
);

   logic [smae_pkg::CUM_W-1:0] table_mem_ff [smae_pkg::NUM_SYMS];
   logic [smae_pkg::CUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem_ff[wr_addr] <= wr_data;
      end
   end

   // an out-of-range read address occurs only when sym - 1 wraps for sym 0, and that result is unused
   always_ff @(posedge clock) begin
      rd_data_ff <= table_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/smae_muldiv.sv
module smae_muldiv (
   input  logic                             clock,
   input  logic                             reset,
   input  smae_pkg::muldiv_ctrl_type        ctrl,
   input  logic [smae_pkg::RANGE_W-1:0]     op_range,
   input  logic [smae_pkg::CUM_W-1:0]       op_count,
   input  logic [smae_pkg::CUM_W-1:0]       op_total,
   output smae_pkg::muldiv_stat_type        stat,
   output logic [smae_pkg::RANGE_W-1:0]     quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [smae_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [smae_pkg::CUM_W-1:0]        rem_ff, rem_in;
   logic [smae_pkg::RANGE_W-1:0]      quo_ff, quo_in;

   logic [smae_pkg::PROD_W-1:0]       product;
   logic [smae_pkg::CUM_W:0]          shifted;
   logic [smae_pkg::CUM_W:0]          diff;
   logic                              fits;

   // product < total * 2^33, so its top bits already lie below the divisor
   always_comb begin
      product = smae_pkg::PROD_W'(op_range) * smae_pkg::PROD_W'(op_count);
      shifted = {rem_ff, quo_ff[smae_pkg::RANGE_W-1]};
      diff    = shifted - {1'b0, op_total};
      fits    = (shifted >= {1'b0, op_total});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = product[smae_pkg::PROD_W-1:smae_pkg::RANGE_W];
         quo_in  = product[smae_pkg::RANGE_W-1:0];
      end else if (busy_ff) begin
         rem_in  = fits ? diff[smae_pkg::CUM_W-1:0] : shifted[smae_pkg::CUM_W-1:0];
         quo_in  = {quo_ff[smae_pkg::RANGE_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == smae_pkg::STEP_W'(smae_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

>>> rtl/core/static_model_arithmetic_encoder_unit.sv
// Channel   Dir  Ports                                                   Moves
// --------  ---  ------------------------------------------------------  ------------------------
// req       in   req_valid req_stall req_op req_table_index              one request: load,
//                req_frequency req_symbol                                encode or finish
// rsp       out  rsp_valid rsp_stall rsp_first_bit rsp_follow_count      one emitted code bit
//                rsp_last rsp_stream_end
//
// Sequence: a load is done in the idle state. Encode/finish: table reads (RD_HI, RD_LO, CHECK),
//   two multiply plus 33-step restoring divides (MUL/DIV HI, then MUL/DIV LO) and the renorm steps.
//   A symbol that is not coded ends after the table reads (a finish then still flushes).
// The serial divider of the shared multiply/divide unit takes most of the time.
// Reset: synchronous, active high; the interval and the running sum clear, the table does not.
// Stalls: one result register plus one hold register; renorm waits only when both are full.
module static_model_arithmetic_encoder_unit #(
   parameter int FREQ_BITS = smae_pkg::FREQ_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [smae_pkg::OP_W-1:0]       req_op,
   input  logic [smae_pkg::IDX_W-1:0]      req_table_index,
   input  logic [smae_pkg::FREQ_W-1:0]     req_frequency,
   input  logic [smae_pkg::SYM_W-1:0]      req_symbol,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_first_bit,
   output logic [smae_pkg::CODE_W-1:0]     rsp_follow_count,
   output logic                            rsp_last,
   output logic                            rsp_stream_end
);

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RD_HI  = 4'd1;
   localparam logic [3:0] ST_RD_LO  = 4'd2;
   localparam logic [3:0] ST_CHECK  = 4'd3;
   localparam logic [3:0] ST_MUL_HI = 4'd4;
   localparam logic [3:0] ST_DIV_HI = 4'd5;
   localparam logic [3:0] ST_MUL_LO = 4'd6;
   localparam logic [3:0] ST_DIV_LO = 4'd7;
   localparam logic [3:0] ST_RENORM = 4'd8;
   localparam logic [3:0] ST_FLUSH  = 4'd9;
   localparam logic [3:0] ST_DRAIN  = 4'd10;

   // largest effective frequency
   localparam logic [smae_pkg::FREQ_W-1:0] FREQ_MAX =
      smae_pkg::FREQ_W'((32'd1 << FREQ_BITS) - 32'd1);

   logic [3:0]                        state_ff, state_in;
   logic [smae_pkg::IDX_W-1:0]        sym_ff, sym_in;
   logic                              finish_ff, finish_in;
   logic [smae_pkg::CUM_W-1:0]        hi_c_ff, hi_c_in;
   logic [smae_pkg::CUM_W-1:0]        lo_c_ff, lo_c_in;
   logic [smae_pkg::RANGE_W-1:0]      range_ff, range_in;
   logic [smae_pkg::CODE_W-1:0]       low_ff, low_in;
   logic [smae_pkg::CODE_W-1:0]       high_ff, high_in;
   logic [smae_pkg::CODE_W-1:0]       pending_ff, pending_in;
   logic [smae_pkg::CUM_W-1:0]        sum_ff, sum_in;

   // hold register: the newest emitted bit waits here until we know whether it is the last
   logic                              hold_valid_ff, hold_valid_in;
   logic                              hold_bit_ff, hold_bit_in;
   logic [smae_pkg::CODE_W-1:0]       hold_count_ff, hold_count_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_bit_ff, rsp_bit_in;
   logic [smae_pkg::CODE_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              rsp_end_ff, rsp_end_in;

   // table port
   logic                              tbl_wr_en;
   logic [smae_pkg::IDX_W-1:0]        tbl_rd_addr;
   logic [smae_pkg::CUM_W-1:0]        tbl_rd_data;

   // shared multiply/divide unit
   smae_pkg::muldiv_ctrl_type         md_ctrl;
   smae_pkg::muldiv_stat_type         md_stat;
   logic [smae_pkg::CUM_W-1:0]        md_count;
   logic [smae_pkg::RANGE_W-1:0]      md_quo;

   // load datapath
   logic [smae_pkg::FREQ_W-1:0]       eff_freq;
   logic [smae_pkg::CUM_W-1:0]        sum_base;
   logic [smae_pkg::CUM_W:0]          sum_wide;
   logic [smae_pkg::CUM_W-1:0]        sum_new;

   // renorm decode
   logic                              take;
   logic                              out_free;
   logic                              e1, e2, e3;
   logic [smae_pkg::CODE_W-1:0]       pend_inc;
   logic [smae_pkg::CUM_W-1:0]        lo_c_val;
   logic [smae_pkg::RANGE_W-1:0]      high_calc;

   assign req_stall = (state_ff != ST_IDLE);
   assign take      = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // effective frequency: zero counts as one, saturated to the table's precision
   always_comb begin
      eff_freq = (req_frequency == '0) ? smae_pkg::FREQ_W'(1) : req_frequency;
      if (eff_freq > FREQ_MAX) begin
         eff_freq = FREQ_MAX;
      end
      sum_base = (req_table_index == '0) ? '0 : sum_ff;
      sum_wide = {1'b0, sum_base} + (smae_pkg::CUM_W + 1)'(eff_freq);
      sum_new  = sum_wide[smae_pkg::CUM_W] ? smae_pkg::CUM_MAX : sum_wide[smae_pkg::CUM_W-1:0];
   end

   assign tbl_wr_en   = take && (req_op == smae_pkg::OP_LOAD) &&
                        (req_table_index <= smae_pkg::END_SYM);
   // RD_HI reads sym, RD_LO reads sym - 1; the registered data shows up in the following cycle
   assign tbl_rd_addr = (state_ff == ST_RD_LO) ? (sym_ff - 1'b1) : sym_ff;

   smae_cum_table u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (req_table_index),
      .wr_data (sum_new),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign md_ctrl.start = (state_ff == ST_MUL_HI) || (state_ff == ST_MUL_LO);
   assign md_count      = (state_ff == ST_MUL_LO) ? lo_c_ff : hi_c_ff;

   smae_muldiv u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (md_ctrl),
      .op_range (range_ff),
      .op_count (md_count),
      .op_total (sum_ff),
      .stat     (md_stat),
      .quotient (md_quo)
   );

   // E1: all below half, E2: all above half, E3: straddles the midpoint inside the middle half
   always_comb begin
      e1       = (high_ff < smae_pkg::HALF);
      e2       = (low_ff >= smae_pkg::HALF);
      e3       = (low_ff >= smae_pkg::QTR) && (high_ff < smae_pkg::THREE_QTR);
      pend_inc = (pending_ff == smae_pkg::TOP) ? smae_pkg::TOP : (pending_ff + 1'b1);
      lo_c_val = (sym_ff == '0) ? '0 : smae_pkg::clamp_cum(tbl_rd_data, sum_ff);
      high_calc = {1'b0, low_ff} + md_quo - 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      sym_in        = sym_ff;
      finish_in     = finish_ff;
      hi_c_in       = hi_c_ff;
      lo_c_in       = lo_c_ff;
      range_in      = range_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      pending_in    = pending_ff;
      sum_in        = sum_ff;
      hold_valid_in = hold_valid_ff;
      hold_bit_in   = hold_bit_ff;
      hold_count_in = hold_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_bit_in    = rsp_bit_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_end_in    = rsp_end_ff;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (req_op)
                  smae_pkg::OP_LOAD: begin
                     if (req_table_index <= smae_pkg::END_SYM) begin
                        sum_in = sum_new;
                     end
                  end
                  smae_pkg::OP_ENCODE: begin
                     sym_in    = {1'b0, req_symbol};
                     finish_in = 1'b0;
                     state_in  = ST_RD_HI;
                  end
                  smae_pkg::OP_FINISH: begin
                     sym_in    = smae_pkg::END_SYM;
                     finish_in = 1'b1;
                     state_in  = ST_RD_HI;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD_HI: begin
            state_in = ST_RD_LO;
         end
         ST_RD_LO: begin
            hi_c_in  = smae_pkg::clamp_cum(tbl_rd_data, sum_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // empty slot (zero total or inconsistent table): symbol is not coded
            if ((sum_ff == '0) || (hi_c_ff <= lo_c_val)) begin
               state_in = finish_ff ? ST_FLUSH : ST_IDLE;
            end else begin
               lo_c_in  = lo_c_val;
               range_in = {1'b0, high_ff} - {1'b0, low_ff} + 1'b1;
               state_in = ST_MUL_HI;
            end
         end
         ST_MUL_HI: begin
            state_in = ST_DIV_HI;
         end
         ST_DIV_HI: begin
            if (md_stat.done) begin
               high_in  = high_calc[smae_pkg::CODE_W-1:0];
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            state_in = ST_DIV_LO;
         end
         ST_DIV_LO: begin
            if (md_stat.done) begin
               low_in   = low_ff + md_quo[smae_pkg::CODE_W-1:0];
               state_in = ST_RENORM;
            end
         end
         ST_RENORM: begin
            if (e1 || e2) begin
               if (!hold_valid_ff || out_free) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_bit_in   = hold_bit_ff;
                     rsp_count_in = hold_count_ff;
                     rsp_last_in  = 1'b0;
                     rsp_end_in   = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_bit_in   = !e1;
                  hold_count_in = pending_ff;
                  pending_in    = '0;
                  // (x - HALF) * 2 and x * 2 agree in the low 32 bits
                  low_in        = {low_ff[smae_pkg::CODE_W-2:0], 1'b0};
                  high_in       = {high_ff[smae_pkg::CODE_W-2:0], 1'b1};
               end
            end else if (e3) begin
               pending_in = pend_inc;
               low_in     = (low_ff - smae_pkg::QTR) << 1;
               high_in    = ((high_ff - smae_pkg::QTR) << 1) | smae_pkg::CODE_W'(1);
            end else begin
               state_in = finish_ff ? ST_FLUSH : ST_DRAIN;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (hold_valid_ff) begin
                  rsp_bit_in    = hold_bit_ff;
                  rsp_count_in  = hold_count_ff;
                  rsp_last_in   = 1'b0;
                  rsp_end_in    = 1'b0;
                  hold_valid_in = 1'b0;
               end else begin
                  // final disambiguating bit, then the coder starts over
                  rsp_bit_in   = (low_ff >= smae_pkg::QTR);
                  rsp_count_in = pend_inc;
                  rsp_last_in  = 1'b1;
                  rsp_end_in   = 1'b1;
                  low_in       = '0;
                  high_in      = smae_pkg::TOP;
                  pending_in   = '0;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_DRAIN: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bit_in    = hold_bit_ff;
               rsp_count_in  = hold_count_ff;
               rsp_last_in   = 1'b1;
               rsp_end_in    = 1'b0;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         low_ff        <= '0;
         high_ff       <= smae_pkg::TOP;
         pending_ff    <= '0;
         sum_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         pending_ff    <= pending_in;
         sum_ff        <= sum_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      finish_ff     <= finish_in;
      hi_c_ff       <= hi_c_in;
      lo_c_ff       <= lo_c_in;
      range_ff      <= range_in;
      hold_bit_ff   <= hold_bit_in;
      hold_count_ff <= hold_count_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_bit    = rsp_bit_ff;
   assign rsp_follow_count = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_stream_end   = rsp_end_ff;

   // between requests the interval is never empty
   a_interval_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (low_ff < high_ff))
      else $error("coder interval collapsed");

   // no bit may be left behind in the hold register once a request is done
   a_hold_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("hold register still full in idle");

   // divider completions only land in the states waiting for them
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      md_stat.done |-> ((state_ff == ST_DIV_HI) || (state_ff == ST_DIV_LO)))
      else $error("divider finished outside a wait state");

   // the flush bit always closes its request
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_end) |-> rsp_last)
      else $error("stream end without last");

endmodule
